// ----- rtl/tfn_pkg.sv -----
// Shared widths, payload structs and stage control type for the face normal core.
`default_nettype none
package tfn_pkg;
   localparam int COORD_WIDTH      = 16;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int OUT_WIDTH        = 16;
   localparam int EDGE_WIDTH       = COORD_WIDTH + 1;
   localparam int PROD_WIDTH       = 2 * EDGE_WIDTH;
   localparam int CROSS_WIDTH      = PROD_WIDTH + 1;
   localparam int MAG_WIDTH        = PROD_WIDTH;
   localparam int SQ_WIDTH         = 2 * MAG_WIDTH;
   localparam int SUM_WIDTH        = SQ_WIDTH + 2;
   localparam int REM_WIDTH        = SQ_WIDTH + 2 * NORMAL_FRAC_BITS;
   localparam int QUO_WIDTH        = NORMAL_FRAC_BITS + 1;
   localparam int PART_WIDTH       = SUM_WIDTH + QUO_WIDTH;
   localparam int DELTA_WIDTH      = SUM_WIDTH + 2 * NORMAL_FRAC_BITS + 3;
   localparam int STEPS            = NORMAL_FRAC_BITS + 1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] a_x;
      logic signed [COORD_WIDTH-1:0] a_y;
      logic signed [COORD_WIDTH-1:0] a_z;
      logic signed [COORD_WIDTH-1:0] b_x;
      logic signed [COORD_WIDTH-1:0] b_y;
      logic signed [COORD_WIDTH-1:0] b_z;
      logic signed [COORD_WIDTH-1:0] c_x;
      logic signed [COORD_WIDTH-1:0] c_y;
      logic signed [COORD_WIDTH-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] normal_x;
      logic signed [OUT_WIDTH-1:0] normal_y;
      logic signed [OUT_WIDTH-1:0] normal_z;
      logic                        degenerate;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] neg;
   } stage_ctl_type;
endpackage
`default_nettype wire

// ----- rtl/tfn_cross.sv -----
// Edge differences, cross product and sign/magnitude split in three stages.
`default_nettype none
module tfn_cross import tfn_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire req_type                     in_data,
   output      stage_ctl_type               out_ctl,
   output      logic [2:0][MAG_WIDTH-1:0]   out_mag
);
   logic                           e_valid_ff;
   logic signed [EDGE_WIDTH-1:0]   e1_ff [3];
   logic signed [EDGE_WIDTH-1:0]   e2_ff [3];
   logic                           p_valid_ff;
   logic signed [PROD_WIDTH-1:0]   pa_ff [3];
   logic signed [PROD_WIDTH-1:0]   pb_ff [3];
   logic                           n_valid_ff;
   logic [2:0]                     neg_ff;
   logic [2:0][MAG_WIDTH-1:0]      mag_ff;
   logic signed [CROSS_WIDTH-1:0]  n_in [3];

   function automatic logic signed [EDGE_WIDTH-1:0] sub_e(
      input logic signed [COORD_WIDTH-1:0] x, input logic signed [COORD_WIDTH-1:0] y);
      return EDGE_WIDTH'(x) - EDGE_WIDTH'(y);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         n_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= in_valid;
         p_valid_ff <= e_valid_ff;
         n_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff[0] <= sub_e(in_data.b_x, in_data.a_x);
      e1_ff[1] <= sub_e(in_data.b_y, in_data.a_y);
      e1_ff[2] <= sub_e(in_data.b_z, in_data.a_z);
      e2_ff[0] <= sub_e(in_data.c_x, in_data.b_x);
      e2_ff[1] <= sub_e(in_data.c_y, in_data.b_y);
      e2_ff[2] <= sub_e(in_data.c_z, in_data.b_z);
      // N = E2 x E1, each component as a difference of two products.
      pa_ff[0] <= e2_ff[1] * e1_ff[2];
      pb_ff[0] <= e2_ff[2] * e1_ff[1];
      pa_ff[1] <= e2_ff[2] * e1_ff[0];
      pb_ff[1] <= e2_ff[0] * e1_ff[2];
      pa_ff[2] <= e2_ff[0] * e1_ff[1];
      pb_ff[2] <= e2_ff[1] * e1_ff[0];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = CROSS_WIDTH'(pa_ff[i]) - CROSS_WIDTH'(pb_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         neg_ff[i] <= n_in[i][CROSS_WIDTH-1];
         mag_ff[i] <= n_in[i][CROSS_WIDTH-1] ? MAG_WIDTH'(-n_in[i]) : MAG_WIDTH'(n_in[i]);
      end
   end

   assign out_ctl.valid = n_valid_ff;
   assign out_ctl.neg   = neg_ff;
   assign out_mag       = mag_ff;
endmodule
`default_nettype wire

// ----- rtl/tfn_square.sv -----
// One stage that squares the three cross product magnitudes.
`default_nettype none
module tfn_square import tfn_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire stage_ctl_type               in_ctl,
   input  wire logic [2:0][MAG_WIDTH-1:0]   in_mag,
   output      stage_ctl_type               out_ctl,
   output      logic [2:0][SQ_WIDTH-1:0]    out_sq
);
   stage_ctl_type            ctl_ff;
   logic [2:0][SQ_WIDTH-1:0] sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= SQ_WIDTH'(in_mag[i]) * SQ_WIDTH'(in_mag[i]);
      end
   end

   assign out_ctl = ctl_ff;
   assign out_sq  = sq_ff;
endmodule
`default_nettype wire

// ----- rtl/tfn_root_div.sv -----
// Pipelined restoring search for trunc(|N| * 2^F / sqrt(S)), one quotient bit per stage.
`default_nettype none
module tfn_root_div import tfn_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire stage_ctl_type              in_ctl,
   input  wire logic [2:0][SQ_WIDTH-1:0]   in_sq,
   output      logic                       out_valid,
   output      rsp_type                    out_data
);
   // Per stage: R = N^2*2^2F - q^2*S, P = q*S; a trial bit b is kept when
   // (2P + 2^b*S) * 2^b fits in R.
   logic                   v_ff   [0:STEPS];
   logic [SUM_WIDTH-1:0]   s_ff   [0:STEPS];
   logic [2:0]             neg_ff [0:STEPS];
   logic [REM_WIDTH-1:0]   r_ff   [3][0:STEPS];
   logic [PART_WIDTH-1:0]  p_ff   [3][0:STEPS];
   logic [QUO_WIDTH-1:0]   q_ff   [3][0:STEPS];
   logic                   o_valid_ff;
   rsp_type                o_data_ff;
   logic [OUT_WIDTH-1:0]   comp_in [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      s_ff[0]   <= SUM_WIDTH'(in_sq[0]) + SUM_WIDTH'(in_sq[1]) + SUM_WIDTH'(in_sq[2]);
      neg_ff[0] <= in_ctl.neg;
   end

   for (genvar l = 0; l < 3; l++) begin : g_seed
      always_ff @(posedge clock) begin
         r_ff[l][0] <= {in_sq[l], {(2 * NORMAL_FRAC_BITS){1'b0}}};
         p_ff[l][0] <= '0;
         q_ff[l][0] <= '0;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int BIT = NORMAL_FRAC_BITS - k;
      logic [DELTA_WIDTH-1:0] sh;

      assign sh = DELTA_WIDTH'(s_ff[k]) << BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         s_ff[k+1]   <= s_ff[k];
         neg_ff[k+1] <= neg_ff[k];
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [DELTA_WIDTH-1:0] delta;
         logic                   take;

         always_comb begin
            delta = ((DELTA_WIDTH'(p_ff[l][k]) << 1) + sh) << BIT;
            take  = delta <= DELTA_WIDTH'(r_ff[l][k]);
         end

         always_ff @(posedge clock) begin
            if (take) begin
               r_ff[l][k+1] <= REM_WIDTH'(DELTA_WIDTH'(r_ff[l][k]) - delta);
               p_ff[l][k+1] <= p_ff[l][k] + PART_WIDTH'(sh);
               q_ff[l][k+1] <= q_ff[l][k] | (QUO_WIDTH'(1) << BIT);
            end else begin
               r_ff[l][k+1] <= r_ff[l][k];
               p_ff[l][k+1] <= p_ff[l][k];
               q_ff[l][k+1] <= q_ff[l][k];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (s_ff[STEPS] == '0) begin
            comp_in[l] = '0;
         end else if (neg_ff[STEPS][l]) begin
            comp_in[l] = -OUT_WIDTH'(q_ff[l][STEPS]);
         end else begin
            comp_in[l] = OUT_WIDTH'(q_ff[l][STEPS]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      o_data_ff.normal_x   <= comp_in[0];
      o_data_ff.normal_y   <= comp_in[1];
      o_data_ff.normal_z   <= comp_in[2];
      o_data_ff.degenerate <= (s_ff[STEPS] == '0);
   end

   assign out_valid = o_valid_ff;
   assign out_data  = o_data_ff;
endmodule
`default_nettype wire

// ----- rtl/triangle_face_normal_core.sv -----
// Top level of the triangle unit face normal pipeline.
`default_nettype none
//  Channel    | Ports                   | Direction | Meaning
//  -----------+-------------------------+-----------+----------------------------------
//  request    | start, busy, req_data   | in        | vertices A, B, C in signed Q7.8
//  response   | rsp_strobe, rsp_data    | out       | unit normal in Q1.14, degenerate
//
// A request is taken at every clock edge where start is high and busy is low.
// Busy is always low: the pipeline accepts one request per cycle, and every
// request gives exactly one response. The depth is set by the
// three cross product stages, one squaring stage, the sum stage, one stage per
// quotient bit of the square root division (fifteen) and the output register.
// Synchronous reset clears the valid bits of all stages; data registers are
// not reset. The receiver cannot stall, so nothing in the pipeline ever holds.
module triangle_face_normal_core import tfn_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_strobe,
   output      rsp_type rsp_data
);
   stage_ctl_type            cross_ctl;
   logic [2:0][MAG_WIDTH-1:0] cross_mag;
   stage_ctl_type            sq_ctl;
   logic [2:0][SQ_WIDTH-1:0] sq_val;

   // The pipeline never backs up, so a request is taken in every cycle that start is high.
   assign busy = 1'b0;

   tfn_cross u_cross (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .in_data  (req_data),
      .out_ctl  (cross_ctl),
      .out_mag  (cross_mag)
   );

   tfn_square u_square (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (cross_ctl),
      .in_mag  (cross_mag),
      .out_ctl (sq_ctl),
      .out_sq  (sq_val)
   );

   // Sum of squares, then one quotient bit per stage for all three components.
   tfn_root_div u_root_div (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (sq_ctl),
      .in_sq     (sq_val),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );
endmodule
`default_nettype wire

// ----- sim/triangle_face_normal_checker.sv -----
// Checker that predicts and compares face normal responses.
module triangle_face_normal_checker import tfn_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_strobe,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending
);
   rsp_type normals_due[$];

   // Truncated quotient comp * 2^F / sqrt(sq), found bit by bit on squares.
   function automatic logic signed [OUT_WIDTH-1:0] unit_part(logic signed [63:0] comp,
                                                             logic [127:0] sq);
      logic [63:0]  mag;
      logic [191:0] goal;
      logic [191:0] trial;
      logic [15:0]  q;
      logic [15:0]  t;
      mag = comp[63] ? -comp : comp;
      goal = ({128'd0, mag} * {128'd0, mag}) << (2 * NORMAL_FRAC_BITS);
      q = 0;
      for (int b = NORMAL_FRAC_BITS; b >= 0; b--) begin
         t = q | (16'd1 << b);
         trial = {176'd0, t} * {176'd0, t} * {64'd0, sq};
         if (trial <= goal) q = t;
      end
      return comp[63] ? -q : q;
   endfunction

   function automatic rsp_type face_normal(req_type r);
      logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
      logic [127:0] sq;
      rsp_type o;
      e1x = 64'(r.b_x) - 64'(r.a_x);
      e1y = 64'(r.b_y) - 64'(r.a_y);
      e1z = 64'(r.b_z) - 64'(r.a_z);
      e2x = 64'(r.c_x) - 64'(r.b_x);
      e2y = 64'(r.c_y) - 64'(r.b_y);
      e2z = 64'(r.c_z) - 64'(r.b_z);
      nx = e2y * e1z - e2z * e1y;
      ny = e2z * e1x - e2x * e1z;
      nz = e2x * e1y - e2y * e1x;
      // Squares of the components exceed 64 bits, so widen before multiplying.
      sq = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
      o = '0;
      if (sq == 0) o.degenerate = 1'b1;
      else begin
         o.normal_x = unit_part(nx, sq);
         o.normal_y = unit_part(ny, sq);
         o.normal_z = unit_part(nz, sq);
      end
      return o;
   endfunction

   initial fail_count = 0;
   assign pending = normals_due.size();

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) normals_due.push_back(face_normal(req_data));
         if (rsp_strobe) begin
            if (normals_due.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = normals_due.pop_front();
               if (want.normal_x !== rsp_data.normal_x || want.normal_y !== rsp_data.normal_y ||
                   want.normal_z !== rsp_data.normal_z ||
                   want.degenerate !== rsp_data.degenerate) begin
                  $display("%0t: expected %0d %0d %0d deg %b, actual %0d %0d %0d deg %b",
                           $time, want.normal_x, want.normal_y, want.normal_z,
                           want.degenerate, rsp_data.normal_x, rsp_data.normal_y,
                           rsp_data.normal_z, rsp_data.degenerate);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// ----- sim/triangle_face_normal_core_test.sv -----
// Testbench top: drives triangle requests and reports the verdict.
module triangle_face_normal_core_test;
   import tfn_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      idle_cycles = 0;

   always #10 clock = ~clock;

   triangle_face_normal_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   triangle_face_normal_checker check (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending(pending)
   );

   // The watchdog counts cycles in which no request and no response moved.
   // The pipeline depth and the sender's gaps are both far below its limit, so
   // reaching that limit can only mean a hang.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 1000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // A random coordinate, weighted toward the extremes and small values.
   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($signed($urandom_range(0, 6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   // Sends one request after a random gap with start held low, or back-to-back
   // with the previous request when burst is set.
   task automatic send_triangle(input req_type r, input bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 14);
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_coords(input logic [15:0] ax, ay, az, bx, by, bz, cx, cy, cz);
      req_type r;
      r = '{ax, ay, az, bx, by, bz, cx, cy, cz};
      send_triangle(r, 1'b0);
   endtask

   initial begin
      req_type r;
      bit      burst;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: all-zero and repeated vertices are degenerate,
      // collinear points too; axis-aligned normals must come out at full scale.
      send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_coords(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_coords(0, 0, 0, 256, 256, 256, 512, 512, 512);
      send_coords(0, 0, 0, 256, 0, 0, 256, 256, 0);
      send_coords(0, 0, 0, 0, 256, 0, 0, 256, 256);
      send_coords(0, 0, 0, 0, 0, 256, 256, 0, 256);
      send_coords(0, 0, 0, 0, 256, 0, 256, 256, 0);
      send_coords(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                  16'h7FFF, 16'h7FFF, 16'h8000);
      send_coords(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                  16'h8000, 16'h8000, 16'h7FFF);
      send_coords(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                  16'h7FFF, 16'h7FFF, 16'h8000);
      send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0);
      send_coords(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 2, 3, 16'hFFFE, 5, 16'hFFF9);
      send_coords(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                  16'h5555, 16'h5555, 16'hAAAA);

      // Hold off until the pipeline has drained once.
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      @(posedge clock);

      for (int i = 0; i < 1650; i++) begin
         if (i % 200 == 0) burst = $urandom_range(0, 1);
         for (int k = 0; k < 9; k++) r[k*16 +: 16] = pick_coord();
         // Some degenerate triangles: repeat a vertex.
         if ($urandom_range(0, 15) == 0) r[95:48] = r[143:96];
         send_triangle(r, burst && ($urandom_range(0, 7) != 0));
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_square.sv
rtl/tfn_root_div.sv
rtl/triangle_face_normal_core.sv
sim/triangle_face_normal_checker.sv
sim/triangle_face_normal_core_test.sv
